@@ src/abs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_pkg: shared types and constants for the band span block
// Register codes, shape codes, job and span records, queue and root sizes.
// ----------------------------------------------------------------------------
package abs_pkg;

   localparam int COORD_W   = 20;
   localparam int MARGIN_W  = 17;
   localparam int SPAN_W    = 21;
   localparam int SUM_W     = COORD_W + 2;
   localparam int CSR_ADDR_W = 3;

   localparam int SQ_OUT_W   = 20;
   localparam int SQ_IN_W    = 2 * SQ_OUT_W;
   localparam int SQ_REM_W   = SQ_OUT_W + 3;
   localparam int SQ_STEP    = 2;
   localparam int SQ_STAGES  = SQ_OUT_W / SQ_STEP;

   localparam int MQ_DEPTH   = 4;
   localparam int MQ_PTR_W   = $clog2(MQ_DEPTH);
   localparam int MQ_CNT_W   = $clog2(MQ_DEPTH + 1);

   localparam int OQ_DEPTH   = 16;
   localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SHAPE_KIND = 3'd0,
      CSR_BOX_LEFT   = 3'd1,
      CSR_BOX_TOP    = 3'd2,
      CSR_BOX_RIGHT  = 3'd3,
      CSR_BOX_BOTTOM = 3'd4
   } csr_index_type;

   typedef enum logic {
      SHAPE_RECT   = 1'b0,
      SHAPE_CIRCLE = 1'b1
   } shape_type;

   typedef struct packed {
      shape_type                  shape_kind;
      logic signed [COORD_W-1:0]  box_left;
      logic signed [COORD_W-1:0]  box_top;
      logic signed [COORD_W-1:0]  box_right;
      logic signed [COORD_W-1:0]  box_bottom;
   } cfg_type;

   typedef struct packed {
      logic                       axis_columns;
      logic signed [COORD_W-1:0]  band_start;
      logic signed [COORD_W-1:0]  band_end;
      logic signed [MARGIN_W-1:0] margin;
   } req_type;

   typedef struct packed {
      logic                       found;
      logic signed [COORD_W-1:0]  base_lo;
      logic signed [COORD_W-1:0]  base_hi;
   } sq_tag_type;

   typedef struct packed {
      logic [SQ_OUT_W-1:0]        op_a;
      logic [SQ_OUT_W-1:0]        op_b;
      sq_tag_type                 tag;
   } job_type;

   typedef struct packed {
      logic                       found;
      logic signed [SPAN_W-1:0]   span_lo;
      logic signed [SPAN_W-1:0]   span_hi;
   } span_type;

endpackage
`default_nettype wire

@@ src/abs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_front: request classifier
// Picks the across and along pairs, finds the band gap and the found flag,
// and reduces the request to two root operands and two along bases.
// ----------------------------------------------------------------------------
module abs_front (
   input  abs_pkg::cfg_type cfg,
   input  abs_pkg::req_type req,
   output abs_pkg::job_type job
);
   import abs_pkg::*;

   logic signed [COORD_W-1:0]  near_c, far_c, amin_c, amax_c;
   logic [COORD_W-1:0]         gap_c;
   logic                       margin_pos_c;
   logic                       rect_found_c;
   logic signed [COORD_W:0]    w_c, h_c, mn_c, sum_x_c, sum_y_c, radius_c;
   logic signed [COORD_W-1:0]  half_c, cx_c, cy_c, calong_c, cacross_c;
   logic [COORD_W-1:0]         dist_c;
   logic                       circ_found_c;

   always_comb begin
      near_c = req.axis_columns ? cfg.box_left  : cfg.box_top;
      far_c  = req.axis_columns ? cfg.box_right : cfg.box_bottom;
      amin_c = req.axis_columns ? cfg.box_top    : cfg.box_left;
      amax_c = req.axis_columns ? cfg.box_bottom : cfg.box_right;

      if (req.band_end < near_c) begin
         gap_c = COORD_W'((COORD_W+1)'(near_c) - (COORD_W+1)'(req.band_end));
      end else if (req.band_start > far_c) begin
         gap_c = COORD_W'((COORD_W+1)'(req.band_start) - (COORD_W+1)'(far_c));
      end else begin
         gap_c = '0;
      end

      margin_pos_c = !req.margin[MARGIN_W-1] && (req.margin != '0);
      if (margin_pos_c) begin
         rect_found_c = gap_c < COORD_W'(req.margin[MARGIN_W-2:0]);
      end else begin
         rect_found_c = (req.band_end > near_c) && (req.band_start < far_c);
      end

      w_c      = (COORD_W+1)'(cfg.box_right)  - (COORD_W+1)'(cfg.box_left);
      h_c      = (COORD_W+1)'(cfg.box_bottom) - (COORD_W+1)'(cfg.box_top);
      mn_c     = (w_c < h_c) ? w_c : h_c;
      half_c   = mn_c[COORD_W:1];
      radius_c = (COORD_W+1)'(half_c) + (COORD_W+1)'(req.margin);
      sum_x_c  = (COORD_W+1)'(cfg.box_left) + (COORD_W+1)'(cfg.box_right);
      sum_y_c  = (COORD_W+1)'(cfg.box_top)  + (COORD_W+1)'(cfg.box_bottom);
      cx_c     = sum_x_c[COORD_W:1];
      cy_c     = sum_y_c[COORD_W:1];
      calong_c  = req.axis_columns ? cy_c : cx_c;
      cacross_c = req.axis_columns ? cx_c : cy_c;

      if (req.band_end < cacross_c) begin
         dist_c = COORD_W'((COORD_W+1)'(cacross_c) - (COORD_W+1)'(req.band_end));
      end else if (req.band_start > cacross_c) begin
         dist_c = COORD_W'((COORD_W+1)'(req.band_start) - (COORD_W+1)'(cacross_c));
      end else begin
         dist_c = '0;
      end
      circ_found_c = $signed({2'b00, dist_c}) < (COORD_W+2)'(radius_c);

      job = '0;
      unique case (cfg.shape_kind)
         SHAPE_RECT: begin
            job.tag.found   = rect_found_c;
            job.tag.base_lo = amin_c;
            job.tag.base_hi = amax_c;
            if (margin_pos_c && rect_found_c) begin
               job.op_a = SQ_OUT_W'(req.margin[MARGIN_W-2:0]);
               job.op_b = SQ_OUT_W'(gap_c);
            end
         end
         SHAPE_CIRCLE: begin
            job.tag.found   = circ_found_c;
            job.tag.base_lo = calong_c;
            job.tag.base_hi = calong_c;
            if (circ_found_c) begin
               job.op_a = radius_c[SQ_OUT_W-1:0];
               job.op_b = SQ_OUT_W'(dist_c);
            end
         end
         default: job = '0;
      endcase
   end

endmodule
`default_nettype wire

@@ src/abs_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_queue: job queue between classifier and span unit
// Small register queue; lets the request side and the span unit stall apart.
// ----------------------------------------------------------------------------
module abs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  abs_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output abs_pkg::job_type head,
   output logic             empty
);
   import abs_pkg::*;

   job_type               mem_ff [MQ_DEPTH];
   logic [MQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [MQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [MQ_CNT_W-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = count_ff == MQ_CNT_W'(MQ_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + MQ_CNT_W'(do_push) - MQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

@@ src/abs_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_sqrt: pipelined floor square root
// Digit-by-digit root, a fixed number of root bits per stage, no stall.
// ----------------------------------------------------------------------------
module abs_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [abs_pkg::SQ_IN_W-1:0]  in_value,
   input  abs_pkg::sq_tag_type          in_tag,
   output logic                         out_valid,
   output logic [abs_pkg::SQ_OUT_W-1:0] out_root,
   output abs_pkg::sq_tag_type          out_tag
);
   import abs_pkg::*;

   typedef struct packed {
      logic                 valid;
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_OUT_W-1:0]  root;
      logic [SQ_IN_W-1:0]   rad;
      sq_tag_type           tag;
   } stage_type;

   stage_type stage_ff [SQ_STAGES];
   stage_type first_c;

   function automatic stage_type sq_step(input stage_type st);
      stage_type           res;
      logic [SQ_REM_W-1:0] cur;
      logic [SQ_REM_W-1:0] trial;
      res = st;
      for (int k = 0; k < SQ_STEP; k++) begin
         cur   = {res.rem[SQ_REM_W-3:0], res.rad[SQ_IN_W-1 -: 2]};
         trial = SQ_REM_W'({res.root, 2'b01});
         res.rad = {res.rad[SQ_IN_W-3:0], 2'b00};
         if (cur >= trial) begin
            res.rem  = cur - trial;
            res.root = {res.root[SQ_OUT_W-2:0], 1'b1};
         end else begin
            res.rem  = cur;
            res.root = {res.root[SQ_OUT_W-2:0], 1'b0};
         end
      end
      return res;
   endfunction

   always_comb begin
      first_c.valid = in_valid;
      first_c.rem   = '0;
      first_c.root  = '0;
      first_c.rad   = in_value;
      first_c.tag   = in_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SQ_STAGES; s++) begin
            stage_ff[s] <= '0;
         end
      end else begin
         stage_ff[0] <= sq_step(first_c);
         for (int s = 1; s < SQ_STAGES; s++) begin
            stage_ff[s] <= sq_step(stage_ff[s-1]);
         end
      end
   end

   assign out_valid = stage_ff[SQ_STAGES-1].valid;
   assign out_root  = stage_ff[SQ_STAGES-1].root;
   assign out_tag   = stage_ff[SQ_STAGES-1].tag;

endmodule
`default_nettype wire

@@ src/abs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abs_back: span unit
// Squares, difference, square root, span add with saturation, result queue.
// Issue is credit based so the pipeline never stalls.
// ----------------------------------------------------------------------------
module abs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_empty,
   input  abs_pkg::job_type      job,
   output logic                  job_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output abs_pkg::span_type     rsp_span
);
   import abs_pkg::*;

   logic [OQ_CNT_W-1:0]   credits_ff, credits_in;
   logic                  issue, rsp_take;

   logic                  s1_valid_ff;
   logic [SQ_IN_W-1:0]    s1_sq_a_ff, s1_sq_b_ff;
   sq_tag_type            s1_tag_ff;
   logic                  s2_valid_ff;
   logic [SQ_IN_W-1:0]    s2_diff_ff;
   sq_tag_type            s2_tag_ff;

   logic                  sq_valid;
   logic [SQ_OUT_W-1:0]   sq_root;
   sq_tag_type            sq_tag;
   span_type              span_c;

   span_type              oq_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0]   oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic [OQ_CNT_W-1:0]   oq_cnt_ff, oq_cnt_in;

   function automatic logic signed [SPAN_W-1:0] sat_span(input logic signed [SUM_W-1:0] v);
      logic signed [SPAN_W-1:0] res;
      if (v[SUM_W-1] != v[SUM_W-2] || v[SUM_W-2] != v[SPAN_W-1]) begin
         res = v[SUM_W-1] ? {1'b1, {(SPAN_W-1){1'b0}}} : {1'b0, {(SPAN_W-1){1'b1}}};
      end else begin
         res = v[SPAN_W-1:0];
      end
      return res;
   endfunction

   assign rsp_take  = rsp_pop && !rsp_empty;
   assign issue     = !job_empty && (credits_ff != '0);
   assign job_pop   = issue;
   assign rsp_empty = oq_cnt_ff == '0;
   assign rsp_span  = oq_ff[oq_rd_ff];

   always_comb begin
      credits_in = credits_ff + OQ_CNT_W'(rsp_take) - OQ_CNT_W'(issue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credits_ff  <= OQ_CNT_W'(OQ_DEPTH);
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         credits_ff  <= credits_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_sq_a_ff <= job.op_a * job.op_a;
      s1_sq_b_ff <= job.op_b * job.op_b;
      s1_tag_ff  <= job.tag;
      s2_diff_ff <= s1_sq_a_ff - s1_sq_b_ff;
      s2_tag_ff  <= s1_tag_ff;
   end

   abs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_value  (s2_diff_ff),
      .in_tag    (s2_tag_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   always_comb begin
      span_c = '0;
      if (sq_tag.found) begin
         span_c.found   = 1'b1;
         span_c.span_lo = sat_span(SUM_W'(sq_tag.base_lo) - $signed(SUM_W'(sq_root)));
         span_c.span_hi = sat_span(SUM_W'(sq_tag.base_hi) + $signed(SUM_W'(sq_root)));
      end
   end

   always_comb begin
      oq_wr_in  = sq_valid ? oq_wr_ff + 1'b1 : oq_wr_ff;
      oq_rd_in  = rsp_take ? oq_rd_ff + 1'b1 : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + OQ_CNT_W'(sq_valid) - OQ_CNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_valid) begin
         oq_ff[oq_wr_ff] <= span_c;
      end
   end

endmodule
`default_nettype wire

@@ src/analytic_band_span_with_margin.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// analytic_band_span_with_margin: band span of one exclusion shape
// Answers a band query with the along-axis span that the configured rectangle
// or circle blocks, grown by a standoff margin.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the job queue is not full, and
// one result leaves per request, in order. A request is classified as it
// is pushed and enters a four-entry job queue; the span unit squares the
// operands, takes the difference and runs a ten-stage square root (two root
// bits per stage), then adds and saturates the span into a sixteen-entry
// result queue. Write the shape registers only while no request is in
// flight.
// ----------------------------------------------------------------------------
module analytic_band_span_with_margin (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_axis_columns,
   input  logic signed [abs_pkg::COORD_W-1:0]  req_band_start,
   input  logic signed [abs_pkg::COORD_W-1:0]  req_band_end,
   input  logic signed [abs_pkg::MARGIN_W-1:0] req_margin,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_span_found,
   output logic signed [abs_pkg::SPAN_W-1:0]   rsp_span_start,
   output logic signed [abs_pkg::SPAN_W-1:0]   rsp_span_end,
   input  logic                                csr_wr_en,
   input  logic [abs_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [abs_pkg::COORD_W-1:0]         csr_wdata
);
   import abs_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   req_type   req_c;
   job_type   front_job, head_job;
   logic      q_empty, q_pop;
   span_type  span;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_addr))
            CSR_SHAPE_KIND: cfg_in.shape_kind = shape_type'(csr_wdata[0]);
            CSR_BOX_LEFT:   cfg_in.box_left   = csr_wdata;
            CSR_BOX_TOP:    cfg_in.box_top    = csr_wdata;
            CSR_BOX_RIGHT:  cfg_in.box_right  = csr_wdata;
            CSR_BOX_BOTTOM: cfg_in.box_bottom = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_c.axis_columns = req_axis_columns;
      req_c.band_start   = req_band_start;
      req_c.band_end     = req_band_end;
      req_c.margin       = req_margin;
   end

   abs_front u_front (
      .cfg (cfg_ff),
      .req (req_c),
      .job (front_job)
   );

   abs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_job (front_job),
      .full     (req_full),
      .pop      (q_pop),
      .head     (head_job),
      .empty    (q_empty)
   );

   abs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (q_empty),
      .job       (head_job),
      .job_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_span  (span)
   );

   assign rsp_span_found = span.found;
   assign rsp_span_start = span.span_lo;
   assign rsp_span_end   = span.span_hi;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the band span block
// Drives band queries through the request queue and checks every span result
// against an in-bench span calculator. Shape registers change between phases
// while nothing is in flight. Phases vary sender idling and receiver stalls,
// and one phase holds the receiver off long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_top;
   import abs_pkg::*;

   localparam longint COORD_MAX    = 524287;
   localparam longint COORD_MIN    = -524288;
   localparam longint SPAN_MAX     = 1048575;
   localparam longint SPAN_MIN     = -1048576;
   localparam int     SETTLE_WAIT  = 20;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     STALL_LIMIT  = 4000;
   localparam int     REPORT_MAX   = 10;
   localparam int     PHASE_ITEMS  = 220;
   localparam int     PHASE_COUNT  = 8;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic                        req_axis_columns = 1'b0;
   logic signed [COORD_W-1:0]   req_band_start = '0;
   logic signed [COORD_W-1:0]   req_band_end = '0;
   logic signed [MARGIN_W-1:0]  req_margin = '0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic                        rsp_span_found;
   logic signed [SPAN_W-1:0]    rsp_span_start;
   logic signed [SPAN_W-1:0]    rsp_span_end;
   logic                        csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0]       csr_addr = '0;
   logic [COORD_W-1:0]          csr_wdata = '0;

   cfg_type   shape_model = '0;
   req_type   band_query_q[$];
   span_type  span_expect_q[$];
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   bit        hold_phase = 1'b0;
   int        hold_done = 0;
   int        mismatch_count = 0;
   int        quiet_cycles = 0;

   analytic_band_span_with_margin dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_axis_columns (req_axis_columns),
      .req_band_start   (req_band_start),
      .req_band_end     (req_band_end),
      .req_margin       (req_margin),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_span_found   (rsp_span_found),
      .rsp_span_start   (rsp_span_start),
      .rsp_span_end     (rsp_span_end),
      .csr_wr_en        (csr_wr_en),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint root_floor(longint v);
      longint res;
      longint bitv;
      res = 0;
      bitv = longint'(1) << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint band_clearance(longint bs, longint be, longint lo, longint hi);
      if (be < lo) return lo - be;
      if (bs > hi) return bs - hi;
      return 0;
   endfunction

   function automatic logic signed [SPAN_W-1:0] clamp_span(longint v);
      if (v > SPAN_MAX) v = SPAN_MAX;
      if (v < SPAN_MIN) v = SPAN_MIN;
      return v[SPAN_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return v[COORD_W-1:0];
   endfunction

   function automatic span_type blocked_span(cfg_type c, req_type q);
      longint l, t, r, b, bs, be, mg;
      longint near_c, far_c, amin, amax, gap, reach;
      longint w, h, cx, cy, rad, calong, cacross, axis_dist, half;
      bit found;
      span_type s;
      l = longint'(c.box_left);
      t = longint'(c.box_top);
      r = longint'(c.box_right);
      b = longint'(c.box_bottom);
      bs = longint'(q.band_start);
      be = longint'(q.band_end);
      mg = longint'(q.margin);
      if (q.axis_columns) begin
         near_c = l;
         far_c = r;
         amin = t;
         amax = b;
      end else begin
         near_c = t;
         far_c = b;
         amin = l;
         amax = r;
      end
      found = 1'b0;
      s = '0;
      if (c.shape_kind == SHAPE_RECT) begin
         gap = band_clearance(bs, be, near_c, far_c);
         reach = 0;
         if (mg > 0) begin
            if (gap <= 0) begin
               reach = mg;
               found = 1'b1;
            end else if (gap < mg) begin
               reach = root_floor(mg * mg - gap * gap);
               found = 1'b1;
            end
         end else begin
            found = (be > near_c) && (bs < far_c);
         end
         if (found) begin
            s.span_lo = clamp_span(amin - reach);
            s.span_hi = clamp_span(amax + reach);
         end
      end else begin
         w = r - l;
         h = b - t;
         cx = (l + r) >>> 1;
         cy = (t + b) >>> 1;
         rad = (((w < h) ? w : h) >>> 1) + mg;
         calong = q.axis_columns ? cy : cx;
         cacross = q.axis_columns ? cx : cy;
         axis_dist = band_clearance(bs, be, cacross, cacross);
         if (axis_dist < rad) begin
            half = root_floor(rad * rad - axis_dist * axis_dist);
            found = 1'b1;
            s.span_lo = clamp_span(calong - half);
            s.span_hi = clamp_span(calong + half);
         end
      end
      s.found = found;
      return s;
   endfunction

   function automatic req_type query_of(bit ax, longint bs, longint be, longint mg);
      req_type q;
      q.axis_columns = ax;
      q.band_start = bs[COORD_W-1:0];
      q.band_end = be[COORD_W-1:0];
      q.margin = mg[MARGIN_W-1:0];
      return q;
   endfunction

   function automatic cfg_type shape_of(shape_type k, longint l, longint t, longint r,
                                        longint b);
      cfg_type c;
      c.shape_kind = k;
      c.box_left = l[COORD_W-1:0];
      c.box_top = t[COORD_W-1:0];
      c.box_right = r[COORD_W-1:0];
      c.box_bottom = b[COORD_W-1:0];
      return c;
   endfunction

   function automatic cfg_type random_shape();
      cfg_type c;
      longint cx, cy, hw, hh;
      logic signed [COORD_W-1:0] tmp;
      int pick;
      c.shape_kind = shape_type'($urandom_range(1));
      pick = $urandom_range(9);
      if (pick == 0) begin
         c.box_left = COORD_W'($urandom);
         c.box_top = COORD_W'($urandom);
         c.box_right = COORD_W'($urandom);
         c.box_bottom = COORD_W'($urandom);
      end else if (pick == 1) begin
         c.box_left = clamp_coord($urandom_range(1) ? COORD_MAX : COORD_MIN);
         c.box_top = clamp_coord($urandom_range(1) ? COORD_MAX : COORD_MIN);
         c.box_right = clamp_coord($urandom_range(1) ? COORD_MAX : COORD_MIN);
         c.box_bottom = clamp_coord($urandom_range(1) ? COORD_MAX : COORD_MIN);
      end else begin
         cx = longint'($urandom_range(1000000)) - 500000;
         cy = longint'($urandom_range(1000000)) - 500000;
         hw = longint'($urandom_range(3000));
         hh = longint'($urandom_range(3000));
         c.box_left = clamp_coord(cx - hw);
         c.box_right = clamp_coord(cx + hw);
         c.box_top = clamp_coord(cy - hh);
         c.box_bottom = clamp_coord(cy + hh);
         if ($urandom_range(9) == 0) begin
            tmp = c.box_left;
            c.box_left = c.box_right;
            c.box_right = tmp;
         end
         if ($urandom_range(9) == 0) begin
            tmp = c.box_top;
            c.box_top = c.box_bottom;
            c.box_bottom = tmp;
         end
      end
      return c;
   endfunction

   function automatic req_type random_query();
      req_type q;
      longint near_c, far_c, anchor, spread, bs, be, mg, tmp;
      int pick;
      q.axis_columns = 1'($urandom_range(1));
      q.band_start = COORD_W'($urandom);
      q.band_end = COORD_W'($urandom);
      q.margin = MARGIN_W'($urandom);
      if ($urandom_range(99) < 15) return q;
      if (q.axis_columns) begin
         near_c = longint'(shape_model.box_left);
         far_c = longint'(shape_model.box_right);
      end else begin
         near_c = longint'(shape_model.box_top);
         far_c = longint'(shape_model.box_bottom);
      end
      case ($urandom_range(2))
         0: anchor = near_c;
         1: anchor = far_c;
         default: anchor = (near_c + far_c) >>> 1;
      endcase
      pick = $urandom_range(99);
      if (pick < 60) begin
         q.margin = MARGIN_W'(longint'($urandom_range(600)) - 100);
      end else if (pick < 85) begin
         q.margin = MARGIN_W'($urandom_range(4000));
      end
      mg = longint'(q.margin);
      spread = ((mg < 0) ? -mg : mg) + (((far_c > near_c) ? far_c - near_c : near_c - far_c) / 2)
               + 64;
      bs = anchor + longint'($urandom_range(32'(2 * spread))) - spread;
      be = bs + longint'($urandom_range(32'(spread)));
      if ($urandom_range(9) == 0) begin
         tmp = bs;
         bs = be;
         be = tmp;
      end
      q.band_start = clamp_coord(bs);
      q.band_end = clamp_coord(be);
      return q;
   endfunction

   task automatic queue_query(req_type q);
      band_query_q.insert(band_query_q.size(), q);
   endtask

   task automatic drain();
      while (band_query_q.size() != 0 || span_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [COORD_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_SHAPE_KIND: shape_model.shape_kind = shape_type'(data[0]);
         CSR_BOX_LEFT:   shape_model.box_left = data;
         CSR_BOX_TOP:    shape_model.box_top = data;
         CSR_BOX_RIGHT:  shape_model.box_right = data;
         CSR_BOX_BOTTOM: shape_model.box_bottom = data;
         default: ;
      endcase
   endtask

   task automatic write_shape(cfg_type c);
      logic [COORD_W-1:0] kind_word;
      drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      kind_word = COORD_W'($urandom);
      kind_word[0] = c.shape_kind;
      write_reg(CSR_SHAPE_KIND, kind_word);
      write_reg(CSR_BOX_LEFT, c.box_left);
      write_reg(CSR_BOX_TOP, c.box_top);
      write_reg(CSR_BOX_RIGHT, c.box_right);
      write_reg(CSR_BOX_BOTTOM, c.box_bottom);
      // unmapped index must leave the shape alone
      write_reg(CSR_ADDR_W'(CSR_BOX_BOTTOM + 1 + $urandom_range(2)), COORD_W'($urandom));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic mismatch(string field, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("ERROR at %0t: %s expected %0d, got %0d", $time, field, want, got);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            span_expect_q.insert(span_expect_q.size(),
                                 blocked_span(shape_model, band_query_q[0]));
            void'(band_query_q.pop_front());
         end
         if (req_push && req_full) begin
            // hold the request until it is taken
         end else if (band_query_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_push <= 1'b1;
            req_axis_columns <= band_query_q[0].axis_columns;
            req_band_start <= band_query_q[0].band_start;
            req_band_end <= band_query_q[0].band_end;
            req_margin <= band_query_q[0].margin;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      span_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (span_expect_q.size() == 0) begin
               mismatch("unexpected result, span_found", 0, rsp_span_found);
            end else begin
               want = span_expect_q.pop_front();
               if (rsp_span_found !== want.found)
                  mismatch("span_found", want.found, rsp_span_found);
               if (rsp_span_start !== want.span_lo)
                  mismatch("span_start", $signed(want.span_lo), rsp_span_start);
               if (rsp_span_end !== want.span_hi)
                  mismatch("span_end", $signed(want.span_hi), rsp_span_end);
            end
         end
         if (hold_phase && hold_done < HOLD_CYCLES) begin
            rsp_pop <= 1'b0;
            hold_done <= hold_done + 1;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int send_pct[4];
      int recv_pct[4];
      send_pct = '{0, 72, 0, 31};
      recv_pct = '{0, 0, 72, 31};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset shape: degenerate box at the origin
      @(negedge clock);
      queue_query(query_of(0, -5, 5, 0));
      queue_query(query_of(1, -5, 5, 10));
      drain();

      write_shape(shape_of(SHAPE_RECT, -100, -50, 200, 300));
      @(negedge clock);
      queue_query(query_of(0, 0, 10, 0));
      queue_query(query_of(0, -100, -60, 20));
      queue_query(query_of(0, -100, -70, 20));
      queue_query(query_of(0, 310, 400, 5));
      queue_query(query_of(0, -60, -50, 0));
      queue_query(query_of(0, 100, 200, -65536));
      queue_query(query_of(1, COORD_MIN, COORD_MAX, 65535));
      queue_query(query_of(1, 250, 150, 100));
      queue_query(query_of(0, COORD_MAX, COORD_MIN, 65535));
      queue_query(query_of(1, COORD_MIN, COORD_MIN, -1));
      drain();

      write_shape(shape_of(SHAPE_CIRCLE, -100, -50, 200, 300));
      @(negedge clock);
      queue_query(query_of(0, 125, 125, 0));
      queue_query(query_of(0, 0, 10, 0));
      queue_query(query_of(0, 275, 300, 0));
      queue_query(query_of(1, 50, 50, -150));
      queue_query(query_of(1, COORD_MIN, COORD_MAX, 65535));
      queue_query(query_of(0, 200, 100, 10));
      queue_query(query_of(0, 0, 0, -65536));
      drain();

      write_shape(shape_of(SHAPE_CIRCLE, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
      @(negedge clock);
      queue_query(query_of(0, 0, 0, 65535));
      drain();

      write_shape(shape_of(SHAPE_RECT, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      @(negedge clock);
      queue_query(query_of(0, 0, 0, 65535));
      queue_query(query_of(1, COORD_MIN, COORD_MIN, 1));
      drain();

      write_shape(shape_of(SHAPE_CIRCLE, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      @(negedge clock);
      queue_query(query_of(1, COORD_MAX, COORD_MAX, 65535));
      queue_query(query_of(0, -1, -1, -65536));
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_shape(random_shape());
         @(negedge clock);
         send_idle_pct = send_pct[p % 4];
         recv_stall_pct = recv_pct[p % 4];
         hold_phase = (p == 4);
         repeat (PHASE_ITEMS) queue_query(random_query());
         drain();
         @(negedge clock);
         hold_phase = 1'b0;
      end

      drain();
      repeat (SETTLE_WAIT * 2) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/abs_pkg.sv
src/abs_front.sv
src/abs_queue.sv
src/abs_sqrt.sv
src/abs_back.sv
src/analytic_band_span_with_margin.sv
tb/tb_top.sv
